// ===== hdl/shape_pair_overlap_test_macros.svh =====
// Assertion macros for the shape pair overlap test checker.
`ifndef SHAPE_PAIR_OVERLAP_TEST_MACROS_SVH
`define SHAPE_PAIR_OVERLAP_TEST_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SPOT_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("shape pair overlap test: assertion failed");

// Concurrent assertion on the usual clk and rst_n.
`define SPOT_ASSERT(lbl, prop) \
    `SPOT_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// ===== hdl/spot_pkg.sv =====
// Package with shape kinds, test modes and fixed widths for the overlap test.
package spot_pkg;

    localparam int FUNC_W   = 4;
    localparam int RADIUS_W = 15;
    // Limit is the sum of two radii at most
    localparam int LIM_W    = RADIUS_W + 1;
    localparam int SQ_W     = 2 * LIM_W;
    localparam int SUM_W    = SQ_W + 1;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_CIRCLE,
        KIND_POINT,
        KIND_PIXEL
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_BOX,
        MODE_CIRC
    } mode_t;

endpackage

// ===== hdl/shape_pair_overlap_test.sv =====
// Top level: five-stage pipelined rectangle / circle / point overlap test.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | to block  | in_valid / in_ready   | func, a_x0..a_radius, b_x0..b_radius
//  out     | from block| out_valid / out_ready | hit
//
//  One pair enters per cycle while the output side does not stall; the hit
//  for it shows on out_valid once it has passed every stage. The depth is set by
//  the chain order / subtract / abs and compare / square / sum and compare.
//  Reset clears the stage valid bits only. A stall on out_ready holds the run
//  of full stages at the output end; empty stages ahead of it still fill, so no bubble is kept.
module shape_pair_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spot_pkg::FUNC_W-1:0]         func,
    input  logic signed [COORD_WIDTH-1:0]       a_x0,
    input  logic signed [COORD_WIDTH-1:0]       a_y0,
    input  logic signed [COORD_WIDTH-1:0]       a_x1,
    input  logic signed [COORD_WIDTH-1:0]       a_y1,
    input  logic [spot_pkg::RADIUS_W-1:0]       a_radius,
    input  logic signed [COORD_WIDTH-1:0]       b_x0,
    input  logic signed [COORD_WIDTH-1:0]       b_y0,
    input  logic signed [COORD_WIDTH-1:0]       b_x1,
    input  logic signed [COORD_WIDTH-1:0]       b_y1,
    input  logic [spot_pkg::RADIUS_W-1:0]       b_radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit
);
    import spot_pkg::*;

    localparam int W  = COORD_WIDTH;
    // Difference width: room for coordinate differences and the limit
    localparam int EW = (COORD_WIDTH + 2 > LIM_W + 2) ? COORD_WIDTH + 2 : LIM_W + 2;

    // Stage valid bits and advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5     = !out_valid_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg        <= in_valid;
            if (adv2) v2_reg        <= v1_reg;
            if (adv3) v3_reg        <= v2_reg;
            if (adv4) v4_reg        <= v3_reg;
            if (adv5) out_valid_reg <= v4_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- Stage 1: order corners, pick roles ----------------
    kind_t                 ka, kb;
    logic signed [W-1:0]   ax_lo, ax_hi, ay_lo, ay_hi;
    logic signed [W-1:0]   bx_lo, bx_hi, by_lo, by_hi;
    logic [LIM_W-1:0]      lim_a, lim_b;

    mode_t                 s1_mode_next, s1_mode_reg;
    logic signed [W-1:0]   s1_rx0_next, s1_rx1_next, s1_ry0_next, s1_ry1_next;
    logic signed [W-1:0]   s1_rx0_reg, s1_rx1_reg, s1_ry0_reg, s1_ry1_reg;
    logic signed [W-1:0]   s1_cx_next, s1_cy_next, s1_cx_reg, s1_cy_reg;
    logic [LIM_W-1:0]      s1_lim_next, s1_lim_reg;
    logic signed [W-1:0]   s1_bx0_reg, s1_bx1_reg, s1_by0_reg, s1_by1_reg;

    assign ka = kind_t'(func[3:2]);
    assign kb = kind_t'(func[1:0]);

    assign ax_lo = (a_x0 > a_x1) ? a_x1 : a_x0;
    assign ax_hi = (a_x0 > a_x1) ? a_x0 : a_x1;
    assign ay_lo = (a_y0 > a_y1) ? a_y1 : a_y0;
    assign ay_hi = (a_y0 > a_y1) ? a_y0 : a_y1;
    assign bx_lo = (b_x0 > b_x1) ? b_x1 : b_x0;
    assign bx_hi = (b_x0 > b_x1) ? b_x0 : b_x1;
    assign by_lo = (b_y0 > b_y1) ? b_y1 : b_y0;
    assign by_hi = (b_y0 > b_y1) ? b_y0 : b_y1;

    // A point is a circle of radius zero
    assign lim_a = (ka == KIND_CIRCLE) ? LIM_W'(a_radius) : '0;
    assign lim_b = (kb == KIND_CIRCLE) ? LIM_W'(b_radius) : '0;

    // Map each non-pixel pair onto rectangle versus circle or box versus box; two round shapes use a
    // rectangle shrunk to the second centre and the sum of the radii
    always_comb
    begin
        s1_mode_next = MODE_CIRC;
        s1_rx0_next  = b_x0;
        s1_rx1_next  = b_x0;
        s1_ry0_next  = b_y0;
        s1_ry1_next  = b_y0;
        s1_cx_next   = a_x0;
        s1_cy_next   = a_y0;
        s1_lim_next  = lim_a + lim_b;
        if (ka == KIND_PIXEL || kb == KIND_PIXEL)
        begin
            s1_mode_next = MODE_NONE;
        end
        else if (ka == KIND_RECT)
        begin
            s1_mode_next = (kb == KIND_RECT) ? MODE_BOX : MODE_CIRC;
            s1_rx0_next  = ax_lo;
            s1_rx1_next  = ax_hi;
            s1_ry0_next  = ay_lo;
            s1_ry1_next  = ay_hi;
            s1_cx_next   = b_x0;
            s1_cy_next   = b_y0;
            s1_lim_next  = lim_b;
        end
        else if (kb == KIND_RECT)
        begin
            s1_rx0_next = bx_lo;
            s1_rx1_next = bx_hi;
            s1_ry0_next = by_lo;
            s1_ry1_next = by_hi;
            s1_lim_next = lim_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_mode_reg <= s1_mode_next;
            s1_rx0_reg  <= s1_rx0_next;
            s1_rx1_reg  <= s1_rx1_next;
            s1_ry0_reg  <= s1_ry0_next;
            s1_ry1_reg  <= s1_ry1_next;
            s1_cx_reg   <= s1_cx_next;
            s1_cy_reg   <= s1_cy_next;
            s1_lim_reg  <= s1_lim_next;
            s1_bx0_reg  <= bx_lo;
            s1_bx1_reg  <= bx_hi;
            s1_by0_reg  <= by_lo;
            s1_by1_reg  <= by_hi;
        end
    end

    // ---------------- Stage 2: differences, box overlap ----------------
    logic signed [EW-1:0]  s2_dx0_next, s2_dx1_next, s2_dy0_next, s2_dy1_next;
    logic signed [EW-1:0]  s2_dx0_reg, s2_dx1_reg, s2_dy0_reg, s2_dy1_reg;
    logic                  s2_rr_next, s2_rr_reg;
    mode_t                 s2_mode_reg;
    logic [LIM_W-1:0]      s2_lim_reg;

    assign s2_dx0_next = EW'(s1_cx_reg) - EW'(s1_rx0_reg);
    assign s2_dx1_next = EW'(s1_cx_reg) - EW'(s1_rx1_reg);
    assign s2_dy0_next = EW'(s1_cy_reg) - EW'(s1_ry0_reg);
    assign s2_dy1_next = EW'(s1_cy_reg) - EW'(s1_ry1_reg);
    assign s2_rr_next  = !(s1_rx0_reg > s1_bx1_reg || s1_rx1_reg < s1_bx0_reg ||
                           s1_ry0_reg > s1_by1_reg || s1_ry1_reg < s1_by0_reg);

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            s2_dx0_reg  <= s2_dx0_next;
            s2_dx1_reg  <= s2_dx1_next;
            s2_dy0_reg  <= s2_dy0_next;
            s2_dy1_reg  <= s2_dy1_next;
            s2_rr_reg   <= s2_rr_next;
            s2_mode_reg <= s1_mode_reg;
            s2_lim_reg  <= s1_lim_reg;
        end
    end

    // ---------------- Stage 3: magnitudes and limit compares ----------------
    logic signed [EW-1:0]  lim_s;
    logic signed [EW-1:0]  mag [4];
    logic [3:0]            s3_near_next, s3_near_reg;
    logic                  s3_span_next, s3_span_reg;
    logic                  s3_box_next, s3_box_reg;
    logic [LIM_W-1:0]      s3_mag_reg [4];
    logic                  s3_rr_reg;
    mode_t                 s3_mode_reg;
    logic [LIM_W-1:0]      s3_lim_reg;

    assign lim_s  = $signed(EW'(s2_lim_reg));
    assign mag[0] = (s2_dx0_reg < 0) ? -s2_dx0_reg : s2_dx0_reg;
    assign mag[1] = (s2_dx1_reg < 0) ? -s2_dx1_reg : s2_dx1_reg;
    assign mag[2] = (s2_dy0_reg < 0) ? -s2_dy0_reg : s2_dy0_reg;
    assign mag[3] = (s2_dy1_reg < 0) ? -s2_dy1_reg : s2_dy1_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s3_near_next[i] = (mag[i] <= lim_s);
        end
    end

    // Centre inside the x span or the y span selects the widened box test
    assign s3_span_next = (s2_dx0_reg >= 0 && s2_dx1_reg <= 0) ||
                          (s2_dy0_reg >= 0 && s2_dy1_reg <= 0);
    assign s3_box_next  = (-s2_dx0_reg <= lim_s) && (s2_dx1_reg <= lim_s) &&
                          (-s2_dy0_reg <= lim_s) && (s2_dy1_reg <= lim_s);

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            s3_near_reg <= s3_near_next;
            s3_span_reg <= s3_span_next;
            s3_box_reg  <= s3_box_next;
            for (int i = 0; i < 4; i++)
            begin
                // Only read when within the limit, so the low bits suffice
                s3_mag_reg[i] <= mag[i][LIM_W-1:0];
            end
            s3_rr_reg   <= s2_rr_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_lim_reg  <= s2_lim_reg;
        end
    end

    // ---------------- Stage 4: squares ----------------
    logic [SQ_W-1:0]       s4_sq_reg [4];
    logic [SQ_W-1:0]       s4_lim_sq_reg;
    logic [3:0]            s4_near_reg;
    logic                  s4_span_reg, s4_box_reg, s4_rr_reg;
    mode_t                 s4_mode_reg;

    always_ff @(posedge clk)
    begin
        if (adv4 && v3_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s4_sq_reg[i] <= SQ_W'(s3_mag_reg[i]) * SQ_W'(s3_mag_reg[i]);
            end
            s4_lim_sq_reg <= SQ_W'(s3_lim_reg) * SQ_W'(s3_lim_reg);
            s4_near_reg   <= s3_near_reg;
            s4_span_reg   <= s3_span_reg;
            s4_box_reg    <= s3_box_reg;
            s4_rr_reg     <= s3_rr_reg;
            s4_mode_reg   <= s3_mode_reg;
        end
    end

    // ---------------- Stage 5: corner distances, final hit ----------------
    logic [3:0]            corner;
    logic                  circ_hit;
    logic                  hit_next, hit_reg;

    // Corner index: bit 0 picks x1 over x0, bit 1 picks y1 over y0
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            corner[j] = s4_near_reg[j % 2] && s4_near_reg[2 + j / 2] &&
                        (SUM_W'(s4_sq_reg[j % 2]) + SUM_W'(s4_sq_reg[2 + j / 2]) <=
                         SUM_W'(s4_lim_sq_reg));
        end
    end

    assign circ_hit = s4_span_reg ? s4_box_reg : (|corner);

    always_comb
    begin
        case (s4_mode_reg)
            MODE_BOX:  hit_next = s4_rr_reg;
            MODE_CIRC: hit_next = circ_hit;
            MODE_NONE: hit_next = 1'b0;
            default:   hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && v4_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== hdl/spot_checker.sv =====
// Port-level checker for the shape pair overlap test, bound to the top level.
`include "shape_pair_overlap_test_macros.svh"

module spot_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit
);

    // Hold a stalled result
    `SPOT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit))

    // Take input whenever the output side can drain
    `SPOT_ASSERT(a_in_ready, (!out_valid || out_ready) |-> in_ready)

    // Deliver a transfer on out_valid when out_ready stays high behind it
    `SPOT_ASSERT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the rectangle / circle / point overlap test block.
`timescale 1ns / 100ps

module tb;
    import spot_pkg::*;

    localparam int CW        = 16;
    localparam int N_RANDOM  = 800;
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic [CW-1:0]       x0;
        logic [CW-1:0]       y0;
        logic [CW-1:0]       x1;
        logic [CW-1:0]       y1;
        logic [RADIUS_W-1:0] r;
    } shape_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        shape_t            a;
        shape_t            b;
    } pair_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THREE_OF_FOUR,
        RX_SPARSE
    } rx_mode_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    logic     out_valid;
    logic     out_ready = 1'b0;
    logic     hit;
    pair_t    offered = '0;

    pair_t    pending[$];
    bit       hit_expect[$];
    logic     in_took = 1'b0;
    int       n_total;
    int       n_in;
    int       n_out;
    int       n_hits;
    int       n_fail;
    bit [15:0] func_seen;

    int       burst_left = 8;
    int       gap_left;
    int       hold_left;
    bit       held_once;
    int       mode_left;
    int       rx_tick;
    rx_mode_t rx_mode = RX_OPEN;

    shape_pair_overlap_test #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (offered.func),
        .a_x0     (offered.a.x0),
        .a_y0     (offered.a.y0),
        .a_x1     (offered.a.x1),
        .a_y1     (offered.a.y1),
        .a_radius (offered.a.r),
        .b_x0     (offered.b.x0),
        .b_y0     (offered.b.y0),
        .b_x1     (offered.b.x1),
        .b_y1     (offered.b.y1),
        .b_radius (offered.b.r),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit      (hit)
    );

    // Free-running clock, 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // Overlap predictor
    // ---------------------------------------------------------------
    function automatic longint gap_of(longint p, longint q);
        return (p > q) ? p - q : q - p;
    endfunction

    // Exact squared-distance test, boundary included
    function automatic bit in_reach(longint ax, longint ay, longint bx, longint by,
                                    longint lim);
        longint dx;
        longint dy;
        dx = gap_of(ax, bx);
        dy = gap_of(ay, by);
        if (dx > lim || dy > lim)
            return 1'b0;
        return (dx * dx + dy * dy) <= (lim * lim);
    endfunction

    function automatic bit point_in_box(longint x0, longint y0, longint x1, longint y1,
                                        longint px, longint py);
        return px >= x0 && px <= x1 && py >= y0 && py <= y1;
    endfunction

    // Expanded box when the centre lies within a span, else corner distances
    function automatic bit box_meets_disc(longint x0, longint y0, longint x1, longint y1,
                                          longint cx, longint cy, longint rad);
        if ((x0 <= cx && cx <= x1) || (y0 <= cy && cy <= y1))
            return !(cx < x0 - rad || cx > x1 + rad || cy < y0 - rad || cy > y1 + rad);
        return in_reach(x0, y0, cx, cy, rad) || in_reach(x1, y0, cx, cy, rad) ||
               in_reach(x0, y1, cx, cy, rad) || in_reach(x1, y1, cx, cy, rad);
    endfunction

    function automatic bit overlap_of(pair_t p);
        kind_t  ka;
        kind_t  kb;
        longint ax0, ay0, ax1, ay1, ar;
        longint bx0, by0, bx1, by1, br;
        longint t;
        bit     res;
        ka  = kind_t'(p.func[3:2]);
        kb  = kind_t'(p.func[1:0]);
        ax0 = $signed(p.a.x0);
        ay0 = $signed(p.a.y0);
        ax1 = $signed(p.a.x1);
        ay1 = $signed(p.a.y1);
        ar  = p.a.r;
        bx0 = $signed(p.b.x0);
        by0 = $signed(p.b.y0);
        bx1 = $signed(p.b.x1);
        by1 = $signed(p.b.y1);
        br  = p.b.r;
        // Put rectangle corners in order
        if (ka == KIND_RECT)
        begin
            if (ax0 > ax1)
            begin
                t = ax0; ax0 = ax1; ax1 = t;
            end
            if (ay0 > ay1)
            begin
                t = ay0; ay0 = ay1; ay1 = t;
            end
        end
        if (kb == KIND_RECT)
        begin
            if (bx0 > bx1)
            begin
                t = bx0; bx0 = bx1; bx1 = t;
            end
            if (by0 > by1)
            begin
                t = by0; by0 = by1; by1 = t;
            end
        end
        res = 1'b0;
        case (ka)
            KIND_RECT:
                case (kb)
                    KIND_RECT:   res = !(ax0 > bx1 || ax1 < bx0 || ay0 > by1 || ay1 < by0);
                    KIND_CIRCLE: res = box_meets_disc(ax0, ay0, ax1, ay1, bx0, by0, br);
                    KIND_POINT:  res = point_in_box(ax0, ay0, ax1, ay1, bx0, by0);
                    default:     res = 1'b0;
                endcase
            KIND_CIRCLE:
                case (kb)
                    KIND_RECT:   res = box_meets_disc(bx0, by0, bx1, by1, ax0, ay0, ar);
                    KIND_CIRCLE: res = in_reach(ax0, ay0, bx0, by0, ar + br);
                    KIND_POINT:  res = in_reach(ax0, ay0, bx0, by0, ar);
                    default:     res = 1'b0;
                endcase
            KIND_POINT:
                case (kb)
                    KIND_RECT:   res = point_in_box(bx0, by0, bx1, by1, ax0, ay0);
                    KIND_CIRCLE: res = in_reach(bx0, by0, ax0, ay0, br);
                    KIND_POINT:  res = (ax0 == bx0) && (ay0 == by0);
                    default:     res = 1'b0;
                endcase
            default:
                res = 1'b0;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------
    function automatic logic [FUNC_W-1:0] pair_code(kind_t first, kind_t second);
        return {first, second};
    endfunction

    task automatic add_pair(logic [FUNC_W-1:0] f, int ax0, int ay0, int ax1, int ay1,
                            int ar, int bx0, int by0, int bx1, int by1, int br);
        pair_t p;
        p.func = f;
        p.a.x0 = CW'(ax0);
        p.a.y0 = CW'(ay0);
        p.a.x1 = CW'(ax1);
        p.a.y1 = CW'(ay1);
        p.a.r  = RADIUS_W'(ar);
        p.b.x0 = CW'(bx0);
        p.b.y0 = CW'(by0);
        p.b.x1 = CW'(bx1);
        p.b.y1 = CW'(by1);
        p.b.r  = RADIUS_W'(br);
        pending.push_back(p);
    endtask

    function automatic logic [CW-1:0] wide_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic shape_t wide_shape();
        shape_t s;
        s.x0 = wide_coord();
        s.y0 = wide_coord();
        s.x1 = wide_coord();
        s.y1 = wide_coord();
        case ($urandom_range(0, 5))
            0:       s.r = '0;
            1:       s.r = '1;
            default: s.r = RADIUS_W'($urandom_range(0, 32767));
        endcase
        return s;
    endfunction

    // Shape scattered in a small window so that hits are common
    function automatic shape_t near_shape(int cx, int cy);
        shape_t s;
        s.x0 = CW'(cx + int'($urandom_range(0, 128)) - 64);
        s.y0 = CW'(cy + int'($urandom_range(0, 128)) - 64);
        s.x1 = CW'(cx + int'($urandom_range(0, 128)) - 64);
        s.y1 = CW'(cy + int'($urandom_range(0, 128)) - 64);
        s.r  = RADIUS_W'($urandom_range(0, 48));
        return s;
    endfunction

    task automatic add_random_pair();
        pair_t p;
        kind_t ka;
        kind_t kb;
        int    cx, cy, k, t, sx, sy, dx, dy, hyp_len, total, pick;
        int    leg_a[4] = '{3, 5, 8, 0};
        int    leg_b[4] = '{4, 12, 15, 1};
        int    hyp[4]   = '{5, 13, 17, 1};
        if ($urandom_range(0, 9) == 0)
            p.func = FUNC_W'($urandom_range(0, 15));
        else
            p.func = pair_code(kind_t'($urandom_range(0, 2)), kind_t'($urandom_range(0, 2)));
        ka   = kind_t'(p.func[3:2]);
        kb   = kind_t'(p.func[1:0]);
        cx   = int'($urandom_range(0, 60000)) - 30000;
        cy   = int'($urandom_range(0, 60000)) - 30000;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            p.a = wide_shape();
            p.b = wide_shape();
        end
        else
        begin
            p.a = near_shape(cx, cy);
            p.b = near_shape(cx, cy);
        end
        // Place the second shape at an exact integer distance, one off or on it
        if (pick >= 3 && pick < 7)
        begin
            k       = $urandom_range(1, 200);
            t       = $urandom_range(0, 3);
            sx      = $urandom_range(0, 1) ? 1 : -1;
            sy      = $urandom_range(0, 1) ? 1 : -1;
            dx      = sx * leg_a[t] * k;
            dy      = sy * leg_b[t] * k;
            hyp_len = hyp[t] * k;
            total   = hyp_len + int'($urandom_range(0, 2)) - 1;
            p.b.x0 = CW'($signed(p.a.x0) + dx);
            p.b.y0 = CW'($signed(p.a.y0) + dy);
            // Rectangles extend away from the other shape so the corner matters
            if (ka == KIND_RECT)
            begin
                p.a.x1 = CW'($signed(p.a.x0) - sx * int'($urandom_range(0, 500)));
                p.a.y1 = CW'($signed(p.a.y0) - sy * int'($urandom_range(0, 500)));
            end
            if (kb == KIND_RECT)
            begin
                p.b.x1 = CW'($signed(p.b.x0) + sx * int'($urandom_range(0, 500)));
                p.b.y1 = CW'($signed(p.b.y0) + sy * int'($urandom_range(0, 500)));
            end
            if (ka == KIND_CIRCLE && kb == KIND_CIRCLE)
            begin
                p.a.r = RADIUS_W'($urandom_range(0, total));
                p.b.r = RADIUS_W'(total - int'(p.a.r));
            end
            else
            begin
                p.a.r = RADIUS_W'(total);
                p.b.r = RADIUS_W'(total);
            end
            if (ka == KIND_POINT && kb == KIND_POINT && total == hyp_len)
            begin
                p.b.x0 = p.a.x0;
                p.b.y0 = p.a.y0;
            end
        end
        pending.push_back(p);
    endtask

    // ---------------------------------------------------------------
    // Input driver: bursts of transfers separated by random gaps
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_took)
        begin
            // hold the offered pair until it transfers
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending.size() != 0)
        begin
            offered  <= pending.pop_front();
            in_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Output receiver: changing stall pattern plus one long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held_once && n_in >= 300)
        begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 100);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            rx_tick <= rx_tick + 1;
            case (rx_mode)
                RX_OPEN:          out_ready <= 1'b1;
                RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
                RX_THREE_OF_FOUR: out_ready <= (rx_tick % 4) != 0;
                default:          out_ready <= (rx_tick % 5) == 0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input transfer, check on output transfer
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        bit want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                hit_expect.push_back(overlap_of(offered));
                func_seen[offered.func] = 1'b1;
                n_in = n_in + 1;
            end
            if (out_valid && out_ready)
            begin
                if (hit_expect.size() == 0)
                begin
                    $error("hit: expected none, actual %0b", hit);
                    n_fail = n_fail + 1;
                end
                else
                begin
                    want = hit_expect.pop_front();
                    if (hit !== want)
                    begin
                        $error("hit: expected %0b, actual %0b", want, hit);
                        n_fail = n_fail + 1;
                    end
                    n_hits = n_hits + want;
                end
                n_out = n_out + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed and random pairs, reset, drain and verdict
    // ---------------------------------------------------------------
    initial
    begin
        // Box overlap with swapped corners, touching edge, one apart
        add_pair(pair_code(KIND_RECT, KIND_RECT), 10, 10, 0, 0, 7, 5, 5, 20, 20, 9);
        add_pair(pair_code(KIND_RECT, KIND_RECT), 0, 0, 10, 10, 0, 10, -5, 20, 3, 0);
        add_pair(pair_code(KIND_RECT, KIND_RECT), 0, 0, 10, 10, 0, 11, 0, 20, 10, 0);
        // Circle against box: expanded-box touch and miss
        add_pair(pair_code(KIND_RECT, KIND_CIRCLE), 0, 0, 10, 10, 0, 15, 5, 99, -99, 5);
        add_pair(pair_code(KIND_RECT, KIND_CIRCLE), 0, 0, 10, 10, 0, 16, 5, 0, 0, 5);
        // Circle against box corner at exactly the radius, then one short
        add_pair(pair_code(KIND_RECT, KIND_CIRCLE), 10, 10, 0, 0, 0, 13, 14, 0, 0, 5);
        add_pair(pair_code(KIND_RECT, KIND_CIRCLE), 10, 10, 0, 0, 0, 13, 14, 0, 0, 4);
        add_pair(pair_code(KIND_CIRCLE, KIND_RECT), -3, -4, 0, 0, 5, 0, 0, 9, 9, 0);
        // Point on the box edge and just outside
        add_pair(pair_code(KIND_RECT, KIND_POINT), -5, -5, 5, 5, 0, 5, -5, 77, 77, 3);
        add_pair(pair_code(KIND_RECT, KIND_POINT), 5, 5, -5, -5, 0, 6, 0, 0, 0, 0);
        // Circles touching
        add_pair(pair_code(KIND_CIRCLE, KIND_CIRCLE), 0, 0, 0, 0, 2, 3, 4, 0, 0, 3);
        // Circle and point either order; the circle's own radius counts
        add_pair(pair_code(KIND_CIRCLE, KIND_POINT), 100, 100, 0, 0, 13, 105, 112, 0, 0, 0);
        add_pair(pair_code(KIND_POINT, KIND_CIRCLE), 105, 112, 0, 0, 32767,
                 100, 100, 0, 0, 12);
        add_pair(pair_code(KIND_POINT, KIND_CIRCLE), 105, 112, 0, 0, 0, 100, 100, 0, 0, 13);
        // Extremes of the coordinate range
        add_pair(pair_code(KIND_POINT, KIND_RECT), 0, 0, 0, 0, 0,
                 -32768, -32768, 32767, 32767, 0);
        add_pair(pair_code(KIND_POINT, KIND_POINT), -32768, 32767, 123, -456, 32767,
                 -32768, 32767, -1, 1, 1);
        add_pair(pair_code(KIND_POINT, KIND_POINT), 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // Zero radius acts as a point
        add_pair(pair_code(KIND_CIRCLE, KIND_POINT), -7, 9, 0, 0, 0, -7, 9, 0, 0, 0);
        add_pair(pair_code(KIND_CIRCLE, KIND_CIRCLE), -32768, 0, 0, 0, 32767,
                 32767, 0, 0, 0, 32767);
        add_pair(pair_code(KIND_CIRCLE, KIND_CIRCLE), -32768, 0, 0, 0, 32767,
                 32766, 0, 0, 0, 32767);
        // Pixel kind never hits, even on coincident shapes
        add_pair(pair_code(KIND_RECT, KIND_PIXEL), 0, 0, 5, 5, 5, 0, 0, 5, 5, 5);
        add_pair(pair_code(KIND_CIRCLE, KIND_PIXEL), 0, 0, 5, 5, 5, 0, 0, 5, 5, 5);
        add_pair(pair_code(KIND_POINT, KIND_PIXEL), 0, 0, 5, 5, 5, 0, 0, 5, 5, 5);
        add_pair(pair_code(KIND_PIXEL, KIND_RECT), 0, 0, 5, 5, 5, 0, 0, 5, 5, 5);
        add_pair(pair_code(KIND_PIXEL, KIND_PIXEL), 0, 0, 5, 5, 5, 0, 0, 5, 5, 5);
        repeat (N_RANDOM)
            add_random_pair();
        n_total = pending.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain every expected result, then allow for stray late results
        while (n_out < n_total)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (hit_expect.size() != 0)
        begin
            $error("hit: %0d expected results never arrived", hit_expect.size());
            n_fail = n_fail + 1;
        end

        $display("Checked %0d overlap results (%0d hits) over %0d of 16 kind pairs.",
                 n_out, n_hits, $countones(func_seen));
        $display("Output was held off %0d cycles once while input kept streaming.",
                 LONG_HOLD);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/spot_pkg.sv
hdl/shape_pair_overlap_test.sv
hdl/spot_checker.sv
tb/tb.sv
